// File: rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths, constants and controller/datapath interface types for the
// linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 21;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = STEP_W + 1;

  localparam logic [STEP_W-1:0] ONE_Q16    = STEP_W'(65536);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_prev;  // prev <= input sample (no-output cases)
    logic skip;       // phase drops by one (downsampling skip)
    logic start;      // latch input sample, load working phase
    logic emit;       // load output register, advance working phase
    logic emit_unit;  // pass the latched sample straight through
    logic last;       // this output closes the run
    logic finish;     // commit prev and phase at end of run
  } lir_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic step_zero;
    logic step_unit;
    logic phase_ge_one;
    logic sum_ge_one;
  } lir_status_t;

endpackage

// File: rtl/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer for the resampler: accepts items, runs one output per cycle
// while the output register is free, and tracks output valid.
// ----------------------------------------------------------------------------
module lir_ctrl import lir_pkg::*; #(
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  lir_status_t status,
  output lir_cmd_t    cmd
);

  localparam int CNT_W = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_UPSAMPLE - 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             unit, unit_next;
  logic             out_valid_next;
  logic             accept;
  logic             slot_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    count_next = count;
    unit_next  = unit;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.step_zero) begin
            cmd.take_prev = 1'b1;
          end else if (status.step_unit) begin
            cmd.start  = 1'b1;
            unit_next  = 1'b1;
            count_next = '0;
            state_next = S_RUN;
          end else if (status.phase_ge_one) begin
            cmd.take_prev = 1'b1;
            cmd.skip      = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            unit_next  = 1'b0;
            count_next = '0;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_unit = unit;
          cmd.last      = unit || status.sum_ge_one || (count == CNT_LAST);
          if (cmd.last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold output valid until taken; set on each emit
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      unit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      unit      <= unit_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/lir_dp.sv
// ----------------------------------------------------------------------------
// lir_dp
// Resampler datapath: step register, previous sample, phase accumulator,
// one-multiplier interpolator and the output register.
// ----------------------------------------------------------------------------
module lir_dp import lir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [STEP_W-1:0]          cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  lir_cmd_t                   cmd,
  output lir_status_t                status,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       run_last
);

  localparam int PROD_W = 2 * (SAMPLE_W + 1);

  logic [STEP_W-1:0]          rate_step;
  logic [STEP_W-1:0]          phase_acc;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] x_reg;
  logic [FRAC_W-1:0]          ph_work;

  logic [SUM_W-1:0]           ph_sum;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   acc;
  logic signed [SAMPLE_W-1:0] interp;

  // Advance phase by one step
  assign ph_sum = SUM_W'(ph_work) + SUM_W'(rate_step);

  assign status.step_zero    = (rate_step == '0);
  assign status.step_unit    = (rate_step == ONE_Q16);
  assign status.phase_ge_one = (phase_acc[STEP_W-1:FRAC_W] != '0);
  assign status.sum_ge_one   = (ph_sum[SUM_W-1:FRAC_W] != '0);

  // prev + (x - prev) * phase, rounded to nearest with ties up
  assign diff   = (SAMPLE_W+1)'(x_reg) - (SAMPLE_W+1)'(prev_sample);
  assign prod   = PROD_W'(diff) * $signed({1'b0, ph_work});
  assign acc    = prod + (PROD_W'(prev_sample) <<< FRAC_W)
                + PROD_W'(32'sd32768);
  assign interp = acc[FRAC_W +: SAMPLE_W];

  // Configuration and carried state
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step   <= STEP_RESET;
      phase_acc   <= '0;
      prev_sample <= '0;
    end else begin
      if (cfg_we) begin
        rate_step <= cfg_wdata;
      end
      if (cmd.take_prev) begin
        prev_sample <= in_sample;
      end
      if (cmd.skip) begin
        phase_acc <= phase_acc - ONE_Q16;
      end
      if (cmd.finish) begin
        prev_sample <= x_reg;
        if (!cmd.emit_unit) begin
          // drop leftover outputs and restart at zero when capped
          phase_acc <= status.sum_ge_one ? STEP_W'(ph_sum - SUM_W'(ONE_Q16)) : '0;
        end
      end
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_reg   <= in_sample;
      ph_work <= phase_acc[FRAC_W-1:0];
    end else if (cmd.emit) begin
      ph_work <= ph_sum[FRAC_W-1:0];
    end
    if (cmd.emit) begin
      out_sample <= cmd.emit_unit ? x_reg : interp;
      run_last   <= cmd.last;
    end
  end

endmodule

// File: rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// One-channel fractional-rate resampler by linear interpolation, with
// signed Q1.15 samples and a Q16 phase accumulator.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------
//   in      | input     | in_valid / in_stall   | in_sample
//   out     | output    | out_valid / out_stall | out_sample, run_last
//   cfg     | input     | cfg_we                | cfg_wdata (rate_step)
//
// An item is taken while idle, then its outputs leave one per cycle from a
// single output register while the output is not stalled, and the input is
// stalled until the last of them (up to MAX_UPSAMPLE outputs per item);
// zero-step and skip items are taken without a run. The output run is
// paced by the single output register. Reset is synchronous and sets the
// step to 1.0 and clears the phase and previous sample. A stall on the
// output holds the run in place.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; #(
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [STEP_W-1:0]          cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       run_last
);

  lir_cmd_t    cmd;
  lir_status_t status;

  // Sequencer
  lir_ctrl #(
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state
  lir_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_sample),
    .cmd        (cmd),
    .status     (status),
    .out_sample (out_sample),
    .run_last   (run_last)
  );

`ifndef SYNTH
  // Idle with a pending output means that output closes its run
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (!in_stall && out_valid) |-> run_last)
    else $error("pending output in idle is not marked last");

  // Busy only after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stalled without an accepted item");

  // Never overwrite a waiting output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule
